FILE: rtl/core/ilrre_pkg.sv
// Shared types and constants for the integer list run/range encoder.
package ilrre_pkg;

  // Fixed field widths of the token channel
  localparam int unsigned OUT_VALUE_W = 32;
  localparam int unsigned RUN_LEN_W   = 16;
  localparam int unsigned BUNDLE_MAX  = 3;
  localparam int unsigned BUNDLE_CW   = 2;

  // Pending-run state
  typedef enum logic [1:0] {
    MODE_EMPTY = 2'd0,
    MODE_ONE   = 2'd1,
    MODE_EQ    = 2'd2,
    MODE_ASC   = 2'd3
  } run_mode_t;

  // Token kinds
  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_REPEAT = 2'd1,
    KIND_RANGE  = 2'd2
  } token_kind_t;

  typedef struct packed {
    token_kind_t              kind;
    logic [OUT_VALUE_W-1:0]   first_value;
    logic [OUT_VALUE_W-1:0]   range_end;
    logic [RUN_LEN_W-1:0]     repeat_count;
    logic                     item_done;
    logic                     list_done;
  } token_t;

  // All tokens caused by one input item, slot 0 first
  typedef struct packed {
    logic [BUNDLE_CW-1:0]       cnt;
    token_t [BUNDLE_MAX-1:0]    tok;
  } bundle_t;

endpackage

FILE: rtl/core/ilrre_core.sv
// Run tracking state and per-item token generation.
module ilrre_core #(
  parameter int unsigned MAX_RUN    = 65535,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic signed [31:0]   in_value,
  input  logic                 in_last_value,
  output ilrre_pkg::bundle_t   bundle
);

  localparam int unsigned VW        = VALUE_BITS;
  localparam int unsigned LIM_CLAMP = (MAX_RUN > 65535) ? 65535 :
                                      ((MAX_RUN < 3) ? 3 : MAX_RUN);
  localparam logic [ilrre_pkg::RUN_LEN_W-1:0] RUN_LIMIT =
    ilrre_pkg::RUN_LEN_W'(LIM_CLAMP);
  localparam logic [VW-1:0] SMAX = {1'b0, {(VW-1){1'b1}}};

  typedef struct packed {
    logic [1:0]        cnt;
    ilrre_pkg::token_t t0;
    ilrre_pkg::token_t t1;
  } pair_t;

  // Tokens that close out a pending run
  function automatic pair_t flush_run(ilrre_pkg::run_mode_t m, logic [VW-1:0] s,
                                      logic [VW-1:0] p,
                                      logic [ilrre_pkg::RUN_LEN_W-1:0] len);
    pair_t r;
    r = '0;
    r.t0.first_value = ilrre_pkg::OUT_VALUE_W'(s);
    r.t1.first_value = ilrre_pkg::OUT_VALUE_W'(p);
    unique case (m)
      ilrre_pkg::MODE_EMPTY: begin
        r.cnt = 2'd0;
      end
      ilrre_pkg::MODE_ONE: begin
        r.cnt = 2'd1;
        r.t0.kind = ilrre_pkg::KIND_SINGLE;
      end
      ilrre_pkg::MODE_EQ: begin
        r.cnt = 2'd1;
        r.t0.kind = ilrre_pkg::KIND_REPEAT;
        r.t0.repeat_count = len;
      end
      ilrre_pkg::MODE_ASC: begin
        if (len <= ilrre_pkg::RUN_LEN_W'(2)) begin
          r.cnt = 2'd2;
          r.t0.kind = ilrre_pkg::KIND_SINGLE;
          r.t1.kind = ilrre_pkg::KIND_SINGLE;
        end else begin
          r.cnt = 2'd1;
          r.t0.kind = ilrre_pkg::KIND_RANGE;
          r.t0.range_end = ilrre_pkg::OUT_VALUE_W'(p);
        end
      end
    endcase
    return r;
  endfunction

  ilrre_pkg::run_mode_t              mode_r, mode_nxt, mode_a;
  logic [VW-1:0]                     start_r, start_nxt, start_a;
  logic [VW-1:0]                     prev_r, prev_nxt, prev_a;
  logic [ilrre_pkg::RUN_LEN_W-1:0]   len_r, len_nxt, len_a;

  logic [VW-1:0] v;
  logic [VW-1:0] prev_inc;
  logic          eq, step, flush_old, below_lim;
  pair_t         fa, fb;
  logic [1:0]    n_a, n_b;

  assign v         = VW'($unsigned(in_value));
  assign prev_inc  = prev_r + VW'(1);
  assign eq        = (v == prev_r);
  // +1 step, never across the top of the signed range
  assign step      = (prev_inc == v) && (prev_r != SMAX);
  assign below_lim = (len_r < RUN_LIMIT);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ilrre_pkg::MODE_EMPTY;
      start_r <= '0;
      prev_r  <= '0;
      len_r   <= '0;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      prev_r  <= prev_nxt;
      len_r   <= len_nxt;
    end
  end

  // Run extension or restart
  always_comb begin
    mode_a    = ilrre_pkg::MODE_ONE;
    start_a   = v;
    prev_a    = v;
    len_a     = ilrre_pkg::RUN_LEN_W'(1);
    flush_old = 1'b0;
    unique case (mode_r)
      ilrre_pkg::MODE_EMPTY: begin
        flush_old = 1'b0;
      end
      ilrre_pkg::MODE_ONE: begin
        if (eq) begin
          mode_a  = ilrre_pkg::MODE_EQ;
          start_a = start_r;
          prev_a  = prev_r;
          len_a   = ilrre_pkg::RUN_LEN_W'(2);
        end else if (step) begin
          mode_a  = ilrre_pkg::MODE_ASC;
          start_a = start_r;
          len_a   = ilrre_pkg::RUN_LEN_W'(2);
        end else begin
          flush_old = 1'b1;
        end
      end
      ilrre_pkg::MODE_EQ: begin
        if (eq && below_lim) begin
          mode_a  = ilrre_pkg::MODE_EQ;
          start_a = start_r;
          prev_a  = prev_r;
          len_a   = len_r + ilrre_pkg::RUN_LEN_W'(1);
        end else begin
          flush_old = 1'b1;
        end
      end
      ilrre_pkg::MODE_ASC: begin
        if (step && below_lim) begin
          mode_a  = ilrre_pkg::MODE_ASC;
          start_a = start_r;
          len_a   = len_r + ilrre_pkg::RUN_LEN_W'(1);
        end else begin
          flush_old = 1'b1;
        end
      end
    endcase

    // End of list clears the run
    if (in_last_value) begin
      mode_nxt  = ilrre_pkg::MODE_EMPTY;
      start_nxt = '0;
      prev_nxt  = '0;
      len_nxt   = '0;
    end else begin
      mode_nxt  = mode_a;
      start_nxt = start_a;
      prev_nxt  = prev_a;
      len_nxt   = len_a;
    end
  end

  assign fa  = flush_run(mode_r, start_r, prev_r, len_r);
  assign fb  = flush_run(mode_a, start_a, prev_a, len_a);
  assign n_a = flush_old ? fa.cnt : 2'd0;
  assign n_b = in_last_value ? fb.cnt : 2'd0;

  // Pack old-run tokens ahead of end-of-list tokens, then flag the final one
  always_comb begin
    bundle     = '0;
    bundle.cnt = n_a + n_b;
    bundle.tok[0] = (n_a != 2'd0) ? fa.t0 : fb.t0;
    case (n_a)
      2'd2:    bundle.tok[1] = fa.t1;
      2'd1:    bundle.tok[1] = fb.t0;
      default: bundle.tok[1] = fb.t1;
    endcase
    case (n_a)
      2'd2:    bundle.tok[2] = fb.t0;
      default: bundle.tok[2] = fb.t1;
    endcase
    for (int i = 0; i < ilrre_pkg::BUNDLE_MAX; i++) begin
      bundle.tok[i].item_done = (bundle.cnt == ilrre_pkg::BUNDLE_CW'(i + 1));
      bundle.tok[i].list_done = in_last_value &&
                                (bundle.cnt == ilrre_pkg::BUNDLE_CW'(i + 1));
    end
  end

`ifndef NO_ASSERTIONS
  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last_value |=> mode_r == ilrre_pkg::MODE_EMPTY)
    else $error("run not cleared after end of list");
  a_run_pending: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_last_value |=> mode_r != ilrre_pkg::MODE_EMPTY)
    else $error("no pending run after a non-final item");
`endif

endmodule

FILE: rtl/core/ilrre_serializer.sv
// Token bundle register that hands tokens out one per transfer.
module ilrre_serializer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_valid,
  output logic                load_ready,
  input  ilrre_pkg::bundle_t  bundle,
  output logic                out_valid,
  input  logic                out_ready,
  output ilrre_pkg::token_t   token
);

  ilrre_pkg::token_t [ilrre_pkg::BUNDLE_MAX-1:0] tok_r, tok_nxt;
  logic [ilrre_pkg::BUNDLE_CW-1:0]               rem_r, rem_nxt;
  logic                                          pop, load;

  assign out_valid  = (rem_r != '0);
  assign token      = tok_r[0];
  assign pop        = out_valid && out_ready;
  // Free when empty or the final token leaves this cycle
  assign load_ready = (rem_r == '0) ||
                      ((rem_r == ilrre_pkg::BUNDLE_CW'(1)) && out_ready);
  assign load       = load_valid && load_ready;

  // Load a new bundle or shift toward slot 0
  always_comb begin
    tok_nxt = tok_r;
    rem_nxt = rem_r;
    if (load) begin
      tok_nxt = bundle.tok;
      rem_nxt = bundle.cnt;
    end else if (pop) begin
      tok_nxt[0] = tok_r[1];
      tok_nxt[1] = tok_r[2];
      rem_nxt    = rem_r - ilrre_pkg::BUNDLE_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (rem_r == '0) || (rem_r == ilrre_pkg::BUNDLE_CW'(1) && pop))
    else $error("bundle loaded over pending tokens");
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r == ilrre_pkg::BUNDLE_CW'(1) |-> tok_r[0].item_done)
    else $error("final token of a bundle lacks item_done");
  a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r > ilrre_pkg::BUNDLE_CW'(1) |-> !tok_r[0].item_done && !tok_r[0].list_done)
    else $error("done flag before the final token of a bundle");
`endif

endmodule

FILE: rtl/core/int_list_run_range_encoder_top.sv
// Top level of the integer list run/range encoder.
// Usage:
//   Input channel (in_valid/in_ready): one list integer per transfer, with
//   in_last_value set on the final integer of a list.
//   Token channel (out_valid/out_ready): single, repeat and range tokens in
//   list order; out_item_done marks the last token an input item caused,
//   out_list_done the final token of the list.
// Output: the tokens an input causes are loaded into the registered bundle
//   register when that input is transferred and leave it in slot order.
// Throughput: one input per cycle while each input causes at most one token
//   and out_ready is high; an input that causes more tokens (up to 3) holds
//   in_ready low until its final token is being taken; this is set by the
//   one-token-per-cycle bundle register feeding the output.
// Reset: rst_n (synchronous, active low) drops any pending run and any
//   buffered tokens; the next input starts a fresh list.
// Stall: while out_ready is low the buffered bundle holds and in_ready stays
//   low as long as any of its tokens is waiting; nothing is lost.
module int_list_run_range_encoder_top #(
  parameter int unsigned MAX_RUN    = 65535,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_value,
  input  logic                in_last_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_token_kind,
  output logic signed [31:0]  out_first_value,
  output logic signed [31:0]  out_range_end,
  output logic [15:0]         out_repeat_count,
  output logic                out_item_done,
  output logic                out_list_done
);

  ilrre_pkg::bundle_t bundle;
  ilrre_pkg::token_t  token;
  logic               acc;

  assign acc = in_valid && in_ready;

  // Run tracking and token generation
  ilrre_core #(
    .MAX_RUN    (MAX_RUN),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .in_value      (in_value),
    .in_last_value (in_last_value),
    .bundle        (bundle)
  );

  // Token output register
  ilrre_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_valid),
    .load_ready (in_ready),
    .bundle     (bundle),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .token      (token)
  );

  assign out_token_kind   = token.kind;
  assign out_first_value  = token.first_value;
  assign out_range_end    = token.range_end;
  assign out_repeat_count = token.repeat_count;
  assign out_item_done    = token.item_done;
  assign out_list_done    = token.list_done;

endmodule
